/* hw/rtl/nfss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the next five-smooth size block.
package nfss_pkg;

    localparam int SIZE_WIDTH_DEF = 32;
    localparam int DATA_W         = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_ENUM,
        S_DRAIN,
        S_WAIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic step;
        logic push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic msb_hit;
        logic last;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/nfss_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the next five-smooth size block.
module nfss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  nfss_pkg::t_sts    i_sts,
    output nfss_pkg::t_cmd    o_cmd
);

    nfss_pkg::t_state r_state;
    nfss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nfss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfss_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = nfss_pkg::S_FIND;
                end
            end
            nfss_pkg::S_FIND: begin
                if (i_sts.msb_hit) begin
                    n_state = nfss_pkg::S_ENUM;
                end
            end
            nfss_pkg::S_ENUM: begin
                if (i_sts.last) begin
                    n_state = nfss_pkg::S_DRAIN;
                end
            end
            nfss_pkg::S_DRAIN: begin
                n_state = nfss_pkg::S_WAIT;
            end
            nfss_pkg::S_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = nfss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            nfss_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            nfss_pkg::S_FIND: begin
                o_cmd.scan = !i_sts.msb_hit;
            end
            nfss_pkg::S_ENUM: begin
                o_cmd.step = 1'b1;
            end
            nfss_pkg::S_DRAIN: begin
                o_cmd = '0;
            end
            nfss_pkg::S_WAIT: begin
                o_cmd.push = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/nfss_dp.sv */
`timescale 1ns / 1ps
// Datapath of the next five-smooth size block: leading-one scan, candidate
// enumeration, minimum tracking and the output register.
module nfss_dp #(
    parameter int SIZE_WIDTH = nfss_pkg::SIZE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  nfss_pkg::t_cmd               i_cmd,
    output nfss_pkg::t_sts               o_sts,
    input  logic [nfss_pkg::DATA_W-1:0]  i_size,
    input  logic                         i_four,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [nfss_pkg::DATA_W-1:0]  o_out_size,
    output logic                         o_out_ovf
);

    localparam int W  = SIZE_WIDTH;
    localparam int IW = $clog2(W);
    localparam int SW = IW + 2;
    localparam int DW = nfss_pkg::DATA_W;
    localparam logic [W-1:0]  LIM  = {W{1'b1}};
    localparam logic [W-1:0]  LIM3 = LIM / 3;
    localparam logic [W-1:0]  LIM5 = LIM / 5;
    localparam logic [SW-1:0] TOP  = SW'(W - 1);

    logic [W-1:0]  r_want;
    logic          r_four;
    logic [IW-1:0] r_idx;
    logic [W-1:0]  r_p3;
    logic [W-1:0]  r_p5;
    logic [IW-1:0] r_e3;
    logic [IW-1:0] r_e5;
    logic [W-1:0]  r_cand;
    logic          r_cand_ok;
    logic [W-1:0]  r_best;
    logic          r_found;
    logic          r_out_valid;
    logic [DW-1:0] r_out_size;
    logic          r_out_ovf;

    logic [W-1:0]  w_size;
    logic [SW-1:0] w_k1;
    logic [SW-1:0] w_kmin;
    logic [SW-1:0] w_k0;
    logic [SW-1:0] w_top;
    logic [W-1:0]  w_m0;
    logic [W-1:0]  w_m1;
    logic          w_ge;
    logic [W-1:0]  n_cand;
    logic          n_cand_ok;
    logic [W-1:0]  w_p5x5;
    logic [W-1:0]  w_p3x3;
    logic [W-1:0]  w_t5;
    logic [W-1:0]  w_t3;
    logic [IW-1:0] n_e5;
    logic [IW-1:0] n_e3;
    logic          w_more5;
    logic          w_more3;

    assign w_size = SIZE_WIDTH'(i_size);

    // Least shift (at least two in multiple-of-four mode) bringing the current
    // product up to the request's length, then one more doubling if still short.
    always_comb begin
        w_k1   = (r_idx > r_e5) ? ({2'b00, r_idx} - {2'b00, r_e5}) : '0;
        w_kmin = r_four ? SW'(2) : '0;
        w_k0   = (w_k1 > w_kmin) ? w_k1 : w_kmin;
        w_top  = {2'b00, r_e5} + w_k0;
        w_m0   = r_p5 << w_k0;
        w_m1   = w_m0 << 1;
        w_ge   = (w_m0 >= r_want);
        if (w_ge) begin
            n_cand    = w_m0;
            n_cand_ok = (w_top <= TOP);
        end else begin
            n_cand    = w_m1;
            n_cand_ok = (w_top < TOP);
        end
    end

    // Next products and their leading-one positions.
    always_comb begin
        w_p5x5  = (r_p5 << 2) + r_p5;
        w_p3x3  = (r_p3 << 1) + r_p3;
        w_t5    = w_p5x5 >> r_e5;
        w_t3    = w_p3x3 >> r_e3;
        n_e5    = r_e5 + (w_t5[3] ? IW'(3) : IW'(2));
        n_e3    = r_e3 + (w_t3[2] ? IW'(2) : IW'(1));
        w_more5 = (r_p5 <= LIM5);
        w_more3 = (r_p3 <= LIM3);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_want <= (w_size == '0) ? W'(1) : w_size;
            r_four <= i_four;
            r_idx  <= IW'(W - 1);
            r_p3   <= W'(1);
            r_p5   <= W'(1);
            r_e3   <= '0;
            r_e5   <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_idx <= r_idx - IW'(1);
            end
            if (i_cmd.step) begin
                if (w_more5) begin
                    r_p5 <= w_p5x5;
                    r_e5 <= n_e5;
                end else if (w_more3) begin
                    r_p3 <= w_p3x3;
                    r_p5 <= w_p3x3;
                    r_e3 <= n_e3;
                    r_e5 <= n_e3;
                end
            end
        end
        r_cand <= n_cand;
        if (r_cand_ok && (!r_found || (r_cand < r_best))) begin
            r_best <= r_cand;
        end
        if (i_cmd.push) begin
            r_out_size <= r_found ? DW'(r_best) : '0;
            r_out_ovf  <= !r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_ok   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cand_ok <= i_cmd.step && n_cand_ok;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (r_cand_ok) begin
                r_found <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.msb_hit  = r_want[r_idx];
    assign o_sts.last     = !w_more5 && !w_more3;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_size  = r_out_size;
    assign o_out_ovf   = r_out_ovf;

endmodule

/* hw/rtl/next_five_smooth_size.sv */
`timescale 1ns / 1ps
// Top level of the next five-smooth size block.
//
// The block takes one requested size per request on the slave stream and
// returns the smallest number at or above it whose only prime factors are
// 2, 3 and 5 on the master stream. A request of zero is treated as one. When
// the mode register is set the answer must also be a multiple of four. If no
// such number fits in SIZE_WIDTH bits the result carries zero with the
// overflow flag set in tuser.
// The mode register is written through its own valid/ready channel, which is
// always ready; it should only be written while the block is idle.
// One request is worked on at a time. After acceptance the datapath scans
// the request for its leading one, one bit per cycle, then walks every
// product of powers of three and five that fits, one per cycle, scaling
// each by the least fitting power of two (157 products for SIZE_WIDTH of
// 32). The minimum is then settled and the output register is loaded once
// it is free; the next request can be taken in the same cycle that the
// result becomes valid.
// The output register frees the input side: a new request is taken while
// a result still waits; if the receiver stalls, the next result waits
// inside the block until the output register empties. Reset clears the
// mode register, the controller and the output valid.
module next_five_smooth_size #(
    parameter int SIZE_WIDTH = nfss_pkg::SIZE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Mode register write channel: bit 0 is require_multiple_of_four.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,
    // Request stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [nfss_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] size_in
    // Result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [nfss_pkg::DATA_W-1:0]  m_axis_tdata,   // [31:0] size_out
    output logic [0:0]                   m_axis_tuser    // [0] overflow
);

    logic           r_four;
    nfss_pkg::t_cmd w_cmd;
    nfss_pkg::t_sts w_sts;
    logic           w_ovf;

    // The mode register takes every write; the user must see that the
    // configuration only changes while the block is idle; nothing enforces it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b0;
        end else if (i_cfg_valid) begin
            r_four <= i_cfg_data;
        end
    end

    nfss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    nfss_dp #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_size      (s_axis_tdata),
        .i_four      (r_four),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_size  (m_axis_tdata),
        .o_out_ovf   (w_ovf)
    );

    assign m_axis_tuser = w_ovf;

    // An overflowed result always carries a zero size.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("overflow result with non-zero size");

    // Only one request is in work: acceptance closes the input side.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted while busy");

    // A fresh result only appears at the end of a search, never while idle.
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a search in progress");

endmodule
